/* hdl/assert_macros.svh */
// assertion macros shared by the deframer rtl
// no dependencies; the user module provides clk and arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, off during reset
`define SFCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define SFCD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SFCD_ASSERT_IMP(lbl, ante, cons, msg)
`define SFCD_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* hdl/sfcd_pkg.sv */
// types, constants and crc helper for the stuffed frame deframer
// no dependencies
package sfcd_pkg;

	// result kinds
	typedef enum logic [2:0] {
		KIND_PAYLOAD = 3'd0,
		KIND_GOOD    = 3'd1,
		KIND_SHORT   = 3'd2,
		KIND_BADCRC  = 3'd3,
		KIND_ABORT   = 3'd4
	} kind_t;

	// register indexes, byte address is 4 times the index
	typedef enum logic [2:0] {
		REG_START_BYTE  = 3'd0,
		REG_END_BYTE    = 3'd1,
		REG_ESCAPE_BYTE = 3'd2,
		REG_ESCAPE_MASK = 3'd3,
		REG_TIMEOUT_MS  = 3'd4
	} reg_idx_t;

	localparam int unsigned APB_ADDR_W = 5;

	localparam logic [7:0]  START_BYTE_RST  = 8'd126;
	localparam logic [7:0]  END_BYTE_RST    = 8'd127;
	localparam logic [7:0]  ESCAPE_BYTE_RST = 8'd125;
	localparam logic [7:0]  ESCAPE_MASK_RST = 8'd32;
	localparam logic [15:0] TIMEOUT_MS_RST  = 16'd100;

	localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
	localparam logic [15:0] CRC_POLY    = 16'h1021;

	// crc-16 xmodem update by one byte, msb first
	function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* hdl/sfcd_item_if.sv */
// input channel: one raw line byte or one millisecond tick per beat
// no dependencies
interface sfcd_item_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink (input valid, input action, input rx_byte, output ready);
endinterface

/* hdl/sfcd_result_if.sv */
// result channel: payload byte or frame status per beat
// depends on sfcd_pkg for the kind type
interface sfcd_result_if
	import sfcd_pkg::*;
;
	logic       valid;
	logic       ready;
	kind_t      kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

/* hdl/stuffed_frame_crc16_deframer.sv */
// byte-stuffed frame receiver with crc-16 xmodem check and tick timeout
// depends on sfcd_pkg, sfcd_item_if, sfcd_result_if and assert_macros.svh
//
//   channel   dir   beat                          accepted when
//   item      in    action, rx_byte               item.valid & item.ready
//   result    out   kind, data_byte               result.valid & result.ready
//   apb       in    register write / read         psel & penable & pwrite
//
// one beat per cycle sustained while the result side is ready; an item passes
// through the input register and then the result register to the result.
// the byte and tick work is a single pass of compare, crc byte update and
// shift logic between the two registers.
// reset clears frame state and loads register defaults; no clearing pass.
// a stalled result blocks the input register only; a new item is still taken
// while the input register is empty.
`include "assert_macros.svh"

module stuffed_frame_crc16_deframer
	import sfcd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	sfcd_item_if.sink             item,
	sfcd_result_if.source         result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	// configuration registers
	logic [7:0]  start_byte_q;
	logic [7:0]  end_byte_q;
	logic [7:0]  escape_byte_q;
	logic [7:0]  escape_mask_q;
	logic [15:0] timeout_ms_q;

	// input stage
	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  byte_s1;

	// frame state
	logic        in_frame_q;
	logic        esc_q;
	logic [16:0] elapsed_q;
	logic [7:0]  held0_q;
	logic [7:0]  held1_q;
	logic [1:0]  held_cnt_q;
	logic [15:0] crc_q;

	// result register
	logic        res_valid_q;
	kind_t       res_kind_q;
	logic [7:0]  res_data_q;

	// next values
	logic        in_frame_d;
	logic        esc_d;
	logic [16:0] elapsed_d;
	logic [7:0]  held0_d;
	logic [7:0]  held1_d;
	logic [1:0]  held_cnt_d;
	logic [15:0] crc_d;
	logic        emit;
	kind_t       emit_kind;
	logic [7:0]  emit_data;

	logic        advance;
	logic        fire_s1;
	logic        wr_en;
	logic [16:0] elapsed_inc;
	logic [7:0]  unesc;

	// apb write and read
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q  <= START_BYTE_RST;
			end_byte_q    <= END_BYTE_RST;
			escape_byte_q <= ESCAPE_BYTE_RST;
			escape_mask_q <= ESCAPE_MASK_RST;
			timeout_ms_q  <= TIMEOUT_MS_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_START_BYTE:  start_byte_q  <= pwdata[7:0];
				REG_END_BYTE:    end_byte_q    <= pwdata[7:0];
				REG_ESCAPE_BYTE: escape_byte_q <= pwdata[7:0];
				REG_ESCAPE_MASK: escape_mask_q <= pwdata[7:0];
				REG_TIMEOUT_MS:  timeout_ms_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_START_BYTE:  prdata = {24'd0, start_byte_q};
			REG_END_BYTE:    prdata = {24'd0, end_byte_q};
			REG_ESCAPE_BYTE: prdata = {24'd0, escape_byte_q};
			REG_ESCAPE_MASK: prdata = {24'd0, escape_mask_q};
			REG_TIMEOUT_MS:  prdata = {16'd0, timeout_ms_q};
			default:         prdata = 32'd0;
		endcase
	end

	// handshake: stage 1 moves when the result register is free or draining
	assign advance    = !res_valid_q || result.ready;
	assign fire_s1    = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			action_s1 <= item.action;
			byte_s1   <= item.rx_byte;
		end
	end

	// per-beat frame logic
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 17'd1;
	assign unesc       = esc_q ? (byte_s1 ^ escape_mask_q) : byte_s1;

	always_comb begin
		in_frame_d = in_frame_q;
		esc_d      = esc_q;
		elapsed_d  = elapsed_q;
		held0_d    = held0_q;
		held1_d    = held1_q;
		held_cnt_d = held_cnt_q;
		crc_d      = crc_q;
		emit       = 1'b0;
		emit_kind  = KIND_ABORT;
		emit_data  = 8'd0;
		if (action_s1) begin
			// millisecond tick
			if (in_frame_q) begin
				elapsed_d = elapsed_inc;
				if (elapsed_inc > {1'b0, timeout_ms_q}) begin
					in_frame_d = 1'b0;
					esc_d      = 1'b0;
					emit       = 1'b1;
					emit_kind  = KIND_ABORT;
				end
			end
		end else if (byte_s1 == start_byte_q) begin
			// start always reopens, aborting an open frame
			in_frame_d = 1'b1;
			esc_d      = 1'b0;
			elapsed_d  = 17'd0;
			held0_d    = 8'd0;
			held1_d    = 8'd0;
			held_cnt_d = 2'd0;
			crc_d      = 16'd0;
			emit       = in_frame_q;
			emit_kind  = KIND_ABORT;
		end else if (in_frame_q) begin
			if (byte_s1 == end_byte_q) begin
				// close and check trailing crc
				in_frame_d = 1'b0;
				esc_d      = 1'b0;
				emit       = 1'b1;
				if (held_cnt_q < 2'd2) begin
					emit_kind = KIND_SHORT;
				end else if ({held0_q, held1_q} == crc_q) begin
					emit_kind = KIND_GOOD;
				end else begin
					emit_kind = KIND_BADCRC;
				end
			end else if (byte_s1 == escape_byte_q) begin
				esc_d = 1'b1;
			end else begin
				esc_d = 1'b0;
				if (held_cnt_q == 2'd2) begin
					// oldest held byte leaves as payload
					crc_d     = crc16_feed(crc_q, held0_q);
					held0_d   = held1_q;
					held1_d   = unesc;
					emit      = 1'b1;
					emit_kind = KIND_PAYLOAD;
					emit_data = held0_q;
				end else begin
					if (held_cnt_q[0]) begin
						held1_d = unesc;
					end else begin
						held0_d = unesc;
					end
					held_cnt_d = held_cnt_q + 2'd1;
				end
			end
		end
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			elapsed_q  <= 17'd0;
			held0_q    <= 8'd0;
			held1_q    <= 8'd0;
			held_cnt_q <= 2'd0;
			crc_q      <= 16'd0;
		end else if (fire_s1) begin
			in_frame_q <= in_frame_d;
			esc_q      <= esc_d;
			elapsed_q  <= elapsed_d;
			held0_q    <= held0_d;
			held1_q    <= held1_d;
			held_cnt_q <= held_cnt_d;
			crc_q      <= crc_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= fire_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			res_kind_q <= emit_kind;
			res_data_q <= emit_data;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.kind      = res_kind_q;
	assign result.data_byte = res_data_q;

	// checks
	`SFCD_ASSERT_IMP(a_held_cnt_range, 1'b1, held_cnt_q != 2'd3, "held byte count out of range")
	`SFCD_ASSERT_IMP(a_esc_only_in_frame, !in_frame_q, !esc_q, "escape pending outside a frame")
	`SFCD_ASSERT_IMP(a_status_no_data, res_valid_q && res_kind_q != KIND_PAYLOAD,
		res_data_q == 8'd0, "status result carries data")
	`SFCD_ASSERT_NXT(a_s1_held_on_stall, valid_s1 && res_valid_q && !result.ready,
		valid_s1, "input stage dropped during result stall")

endmodule
